// File: rtl/core/pfr_pkg.sv
package pfr_pkg;

  localparam int CFG_BITS  = 31;
  localparam int CFG_IDX_W = 1;
  localparam int NUM_LANES = 3;

  localparam logic [CFG_BITS-1:0] MESH_RESET = 31'd65536;
  localparam logic [CFG_BITS-1:0] EPS_RESET  = 31'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESH_SPACING  = 1'b0,
    REG_STIFFNESS_EPS = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ZONE_CONTACT = 2'd0,
    ZONE_NEAR    = 2'd1,
    ZONE_APART   = 2'd2
  } zone_t;

  // pipeline advance and the valid bit of the stage that feeds a unit
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

// File: rtl/core/pfr_sqrt.sv
module pfr_sqrt import pfr_pkg::*; #(
  parameter int DW = 34,
  parameter int PW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pipe_ctl_t       ctl,
  input  logic [2*DW-1:0] rad,
  input  logic [PW-1:0]   pay_in,
  output logic            vld_o,
  output logic [DW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int RW = DW + 3;

  logic [DW-1:0]   v_r;
  logic [2*DW-1:0] rad_r  [DW];
  logic [RW-1:0]   rem_r  [DW];
  logic [DW-1:0]   root_r [DW];
  logic [PW-1:0]   pay_r  [DW];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < DW; k++) begin : g_stage
    localparam int P = (k == 0) ? 0 : k - 1;
    logic            src_v;
    logic [2*DW-1:0] src_rad;
    logic [RW-1:0]   src_rem;
    logic [DW-1:0]   src_root;
    logic [PW-1:0]   src_pay;
    logic [RW-1:0]   rsh;
    logic [RW-1:0]   trial;
    logic            ge;

    assign src_v    = (k == 0) ? ctl.vld : v_r[P];
    assign src_rad  = (k == 0) ? rad     : rad_r[P];
    assign src_rem  = (k == 0) ? '0      : rem_r[P];
    assign src_root = (k == 0) ? '0      : root_r[P];
    assign src_pay  = (k == 0) ? pay_in  : pay_r[P];

    assign rsh   = {src_rem[RW-3:0], src_rad[2*DW-1 -: 2]};
    assign trial = {1'b0, src_root, 2'b01};
    assign ge    = rsh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.en) begin
        v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= ge ? (rsh - trial) : rsh;
        root_r[k] <= {src_root[DW-2:0], ge};
        rad_r[k]  <= src_rad << 2;
        pay_r[k]  <= src_pay;
      end
    end
  end

  assign vld_o  = v_r[DW-1];
  assign root_o = root_r[DW-1];
  assign pay_o  = pay_r[DW-1];

endmodule

// File: rtl/core/pfr_lane.sv
module pfr_lane import pfr_pkg::*; #(
  parameter int MW  = 33,
  parameter int FW  = 68,
  parameter int DVW = 47,
  parameter int QB  = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pipe_ctl_t      ctl,
  input  logic [MW-1:0]  mag,
  input  logic           neg,
  input  logic [1:0]     tag,
  input  logic [FW-1:0]  factor,
  input  logic [DVW-1:0] divisor,
  output logic           vld_o,
  output logic [QB-1:0]  quo_o,
  output logic           ovf_o,
  output logic           neg_o,
  output logic [1:0]     tag_o
);

  localparam int HW  = FW / 2;
  localparam int NW  = MW + FW;
  localparam int HI  = NW - QB;
  localparam int CPW = (HI > DVW) ? HI : DVW;

  // split product: two narrow multiplies, then one wide add
  logic                 p1_v_r, p2_v_r, p3_v_r;
  logic [MW+HW-1:0]     p1_lo_r;
  logic [MW+FW-HW-1:0]  p1_hi_r;
  logic                 p1_neg_r, p2_neg_r, p3_neg_r;
  logic [1:0]           p1_tag_r, p2_tag_r, p3_tag_r;
  logic [DVW-1:0]       p1_div_r, p2_div_r, p3_div_r;
  logic [NW-1:0]        p2_num_r;
  logic [DVW-1:0]       p3_rem_r;
  logic [QB-1:0]        p3_low_r;
  logic                 p3_ovf_r;
  logic [HI-1:0]        num_hi;

  assign num_hi = p2_num_r[NW-1:QB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
    end else if (ctl.en) begin
      p1_v_r <= ctl.vld;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      p1_lo_r  <= (MW+HW)'(mag) * (MW+HW)'(factor[HW-1:0]);
      p1_hi_r  <= (MW+FW-HW)'(mag) * (MW+FW-HW)'(factor[FW-1:HW]);
      p1_neg_r <= neg;
      p1_tag_r <= tag;
      p1_div_r <= divisor;
      p2_num_r <= NW'(p1_lo_r) + (NW'(p1_hi_r) << HW);
      p2_neg_r <= p1_neg_r;
      p2_tag_r <= p1_tag_r;
      p2_div_r <= p1_div_r;
      // a quotient at or above 2^QB always clips
      p3_ovf_r <= CPW'(num_hi) >= CPW'(p2_div_r);
      p3_rem_r <= num_hi[DVW-1:0];
      p3_low_r <= p2_num_r[QB-1:0];
      p3_neg_r <= p2_neg_r;
      p3_tag_r <= p2_tag_r;
      p3_div_r <= p2_div_r;
    end
  end

  logic [QB-1:0]  dv_v_r;
  logic [DVW-1:0] dv_rem_r [QB];
  logic [QB-1:0]  dv_low_r [QB];
  logic [QB-1:0]  dv_q_r   [QB];
  logic [QB-1:0]  dv_ovf_r;
  logic [QB-1:0]  dv_neg_r;
  logic [1:0]     dv_tag_r [QB];
  logic [DVW-1:0] dv_div_r [QB];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    localparam int P = (k == 0) ? 0 : k - 1;
    logic           src_v, src_ovf, src_neg;
    logic [DVW-1:0] src_rem, src_div;
    logic [QB-1:0]  src_low, src_q;
    logic [1:0]     src_tag;
    logic [DVW:0]   trial;
    logic           ge;

    assign src_v   = (k == 0) ? p3_v_r   : dv_v_r[P];
    assign src_ovf = (k == 0) ? p3_ovf_r : dv_ovf_r[P];
    assign src_neg = (k == 0) ? p3_neg_r : dv_neg_r[P];
    assign src_rem = (k == 0) ? p3_rem_r : dv_rem_r[P];
    assign src_div = (k == 0) ? p3_div_r : dv_div_r[P];
    assign src_low = (k == 0) ? p3_low_r : dv_low_r[P];
    assign src_q   = (k == 0) ? '0       : dv_q_r[P];
    assign src_tag = (k == 0) ? p3_tag_r : dv_tag_r[P];

    assign trial = {src_rem, src_low[QB-1]};
    assign ge    = trial >= {1'b0, src_div};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[k] <= 1'b0;
      end else if (ctl.en) begin
        dv_v_r[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        dv_rem_r[k] <= ge ? DVW'(trial - {1'b0, src_div}) : trial[DVW-1:0];
        dv_q_r[k]   <= {src_q[QB-2:0], ge};
        dv_low_r[k] <= src_low << 1;
        dv_ovf_r[k] <= src_ovf;
        dv_neg_r[k] <= src_neg;
        dv_tag_r[k] <= src_tag;
        dv_div_r[k] <= src_div;
      end
    end
  end

  assign vld_o = dv_v_r[QB-1];
  assign quo_o = dv_q_r[QB-1];
  assign ovf_o = dv_ovf_r[QB-1];
  assign neg_o = dv_neg_r[QB-1];
  assign tag_o = dv_tag_r[QB-1];

endmodule

// File: rtl/core/pfr_merge.sv
module pfr_merge import pfr_pkg::*; #(
  parameter int CW = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  logic [NUM_LANES-1:0][CW-1:0]   quo_i,
  input  logic [NUM_LANES-1:0]           ovf_i,
  input  logic [NUM_LANES-1:0]           neg_i,
  input  logic [1:0]                     zone_i,
  output logic                           en_o,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [NUM_LANES*CW-1:0]        force_o,
  output logic [2:0]                     user_o
);

  localparam int EW = NUM_LANES * CW + 3;
  localparam logic [CW-1:0] LIM_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] LIM_NEG = {1'b1, {(CW-1){1'b0}}};

  logic [NUM_LANES-1:0][CW-1:0] frc;
  logic [NUM_LANES-1:0]         clip;
  logic [EW-1:0]                new_ent;
  logic [EW-1:0]                ent0_r, ent1_r;
  logic [1:0]                   cnt_r;
  logic                         push, pop;

  // clip each lane to range, restore the sign, and gather the flags
  always_comb begin
    logic [CW-1:0] lim;
    logic [CW-1:0] m;
    for (int k = 0; k < NUM_LANES; k++) begin
      lim     = neg_i[k] ? LIM_NEG : LIM_POS;
      clip[k] = ovf_i[k] || (quo_i[k] > lim);
      m       = clip[k] ? lim : quo_i[k];
      frc[k]  = neg_i[k] ? (~m + 1'b1) : m;
    end
  end

  assign new_ent   = {|clip, zone_i, frc};
  assign en_o      = cnt_r != 2'd2;
  assign push      = en_o && vld_i;
  assign out_valid = cnt_r != 2'd0;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    case (cnt_r)
      2'd0: begin
        if (push) ent0_r <= new_ent;
      end
      2'd1: begin
        if (push && pop) ent0_r <= new_ent;
        else if (push) ent1_r <= new_ent;
      end
      2'd2: begin
        if (pop) ent0_r <= ent1_r;
      end
      default: begin
        ent0_r <= ent0_r;
      end
    endcase
  end

  assign force_o = ent0_r[NUM_LANES*CW-1:0];
  assign user_o  = ent0_r[EW-1 -: 3];

endmodule

// File: rtl/core/pairwise_repulsion_force_top.sv
// Pairwise repulsion force between two spheres, fully pipelined.
//
// in_*  : one request per particle pair (two centres, two radii).
// out_* : one force result per request, in request order.
// cfg_* : write mesh_spacing (index 0) or stiffness_epsilon (index 1);
//         write only while no request is in flight.
//
// Throughput: one request per clock while in_tready is high. Stages, in order:
// three front stages (difference, square, sum), one stage per root bit in the
// square-root pipe, two stages for zone and factor, three multiply stages plus
// one stage per quotient bit in each force lane, and one output register. The
// square-root pipe and the lane dividers make up most of the depth.
//
// Reset clears all valid bits and the output buffer and loads both config
// registers with 1.0. When the receiver stalls, a two-entry output buffer
// takes one more result; then in_tready drops and the whole pipe holds
// until out_tready frees an entry.
module pairwise_repulsion_force_top import pfr_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32,
  localparam int IN_TW  = ((8 * COORD_WIDTH - 2 + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // center_a_x, center_a_y, center_a_z, center_b_x, center_b_y, center_b_z,
  // radius_a, radius_b (lowest bit up)
  input  logic [IN_TW-1:0]     in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // force_x, force_y, force_z (lowest bit up)
  output logic [OUT_TW-1:0]    out_tdata,
  // zone, saturated (lowest bit up)
  output logic [2:0]           out_tuser,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_BITS-1:0]  cfg_wdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int MW   = CW + 1;                 // |a - b|
  localparam int SQW  = 2 * MW;
  localparam int SW   = SQW + 2;                // sum of three squares, even
  localparam int DW   = SW / 2;                 // root width
  localparam int OW   = ((CW > CFG_BITS + 1) ? CW : CFG_BITS + 1) + 1;
  localparam int FW   = 2 * OW;
  localparam int DVW  = CFG_BITS + FRAC_BITS;
  localparam int CMPW = (DW > OW) ? DW : OW;
  localparam int RS_O = NUM_LANES * (MW + 1);
  localparam int OU_O = RS_O + CW;
  localparam int EP_O = OU_O + OW;
  localparam int PW   = EP_O + CFG_BITS;

  logic                en;
  logic [CFG_BITS-1:0] mesh_r, eps_r;

  // config registers; unknown indexes fall to the default arm
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_r <= MESH_RESET;
      eps_r  <= EPS_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_MESH_SPACING:  mesh_r <= cfg_wdata;
        REG_STIFFNESS_EPS: eps_r  <= cfg_wdata;
        default:           mesh_r <= mesh_r;
      endcase
    end
  end

  // the whole pipe advances together; the output buffer decides
  assign in_tready = en;

  // ---- stage 1: differences, radius sums ----
  logic [NUM_LANES-1:0][MW-1:0] s1_mag;
  logic [NUM_LANES-1:0]         s1_neg;
  logic [CW-2:0]                ra, rb;

  assign ra = in_tdata[6*CW +: CW-1];
  assign rb = in_tdata[7*CW-1 +: CW-1];

  always_comb begin
    logic [CW-1:0] a, b;
    logic [MW-1:0] diff;
    for (int k = 0; k < NUM_LANES; k++) begin
      a         = in_tdata[k*CW +: CW];
      b         = in_tdata[(k+3)*CW +: CW];
      diff      = {a[CW-1], a} - {b[CW-1], b};
      s1_neg[k] = diff[MW-1];
      s1_mag[k] = diff[MW-1] ? (~diff + 1'b1) : diff;
    end
  end

  logic                         s1_v_r, s2_v_r, s3_v_r;
  logic [NUM_LANES-1:0][MW-1:0] s1_mag_r, s2_mag_r, s3_mag_r;
  logic [NUM_LANES-1:0]         s1_neg_r, s2_neg_r, s3_neg_r;
  logic [CW-1:0]                s1_rsum_r, s2_rsum_r, s3_rsum_r;
  logic [OW-1:0]                s1_outer_r, s2_outer_r, s3_outer_r;
  logic [CFG_BITS-1:0]          s1_eps_r, s2_eps_r, s3_eps_r;
  logic [NUM_LANES-1:0][SQW-1:0] s2_sq_r;
  logic [SW-1:0]                s3_sum_r;
  logic [CW-1:0]                rsum;

  assign rsum = CW'(ra) + CW'(rb);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mag_r   <= s1_mag;
      s1_neg_r   <= s1_neg;
      s1_rsum_r  <= rsum;
      s1_outer_r <= OW'(rsum) + OW'({mesh_r, 1'b0});
      // a zero epsilon divides as the raw value 1
      s1_eps_r   <= (eps_r == '0) ? CFG_BITS'(1) : eps_r;
      for (int k = 0; k < NUM_LANES; k++) begin
        s2_sq_r[k] <= SQW'(s1_mag_r[k]) * SQW'(s1_mag_r[k]);
      end
      s2_mag_r   <= s1_mag_r;
      s2_neg_r   <= s1_neg_r;
      s2_rsum_r  <= s1_rsum_r;
      s2_outer_r <= s1_outer_r;
      s2_eps_r   <= s1_eps_r;
      s3_sum_r   <= SW'(s2_sq_r[0]) + SW'(s2_sq_r[1]) + SW'(s2_sq_r[2]);
      s3_mag_r   <= s2_mag_r;
      s3_neg_r   <= s2_neg_r;
      s3_rsum_r  <= s2_rsum_r;
      s3_outer_r <= s2_outer_r;
      s3_eps_r   <= s2_eps_r;
    end
  end

  // ---- square root of the squared distance ----
  pipe_ctl_t     sq_ctl;
  logic [PW-1:0] sq_pay_in, sq_pay;
  logic          sq_v;
  logic [DW-1:0] sq_root;

  assign sq_ctl    = '{en: en, vld: s3_v_r};
  assign sq_pay_in = {s3_eps_r, s3_outer_r, s3_rsum_r, s3_mag_r, s3_neg_r};

  pfr_sqrt #(.DW(DW), .PW(PW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sq_ctl),
    .rad    (s3_sum_r),
    .pay_in (sq_pay_in),
    .vld_o  (sq_v),
    .root_o (sq_root),
    .pay_o  (sq_pay)
  );

  // ---- stage 4: zone and distance margin ----
  logic [CMPW-1:0] d_e, rsum_e, outer_e;
  zone_t           zone;
  logic [OW-1:0]   margin;

  assign d_e     = CMPW'(sq_root);
  assign rsum_e  = CMPW'(sq_pay[RS_O +: CW]);
  assign outer_e = CMPW'(sq_pay[OU_O +: OW]);

  always_comb begin
    if (d_e <= rsum_e) begin
      zone   = ZONE_CONTACT;
      margin = OW'(rsum_e - d_e);
    end else if (d_e <= outer_e) begin
      zone   = ZONE_NEAR;
      margin = OW'(outer_e - d_e);
    end else begin
      zone   = ZONE_APART;
      margin = '0;
    end
  end

  logic                         s4_v_r, s5_v_r;
  zone_t                        s4_zone_r, s5_zone_r;
  logic [OW-1:0]                s4_margin_r;
  logic [NUM_LANES-1:0][MW-1:0] s4_mag_r, s5_mag_r;
  logic [NUM_LANES-1:0]         s4_neg_r, s5_neg_r;
  logic [CFG_BITS-1:0]          s4_eps_r;
  logic [FW-1:0]                s5_factor_r;
  logic [DVW-1:0]               s5_div_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= sq_v;
      s5_v_r <= s4_v_r;
    end
  end

  // ---- stage 5: linear, squared or zero factor, divisor scaled for the zone ----
  always_ff @(posedge clk) begin
    if (en) begin
      s4_zone_r   <= zone;
      s4_margin_r <= margin;
      s4_mag_r    <= sq_pay[NUM_LANES +: NUM_LANES*MW];
      s4_neg_r    <= sq_pay[NUM_LANES-1:0];
      s4_eps_r    <= sq_pay[EP_O +: CFG_BITS];
      case (s4_zone_r)
        ZONE_CONTACT: begin
          s5_factor_r <= FW'(s4_margin_r);
          s5_div_r    <= DVW'(s4_eps_r);
        end
        ZONE_NEAR: begin
          s5_factor_r <= FW'(s4_margin_r) * FW'(s4_margin_r);
          s5_div_r    <= {s4_eps_r, {FRAC_BITS{1'b0}}};
        end
        default: begin
          s5_factor_r <= '0;
          s5_div_r    <= DVW'(s4_eps_r);
        end
      endcase
      s5_zone_r <= s4_zone_r;
      s5_mag_r  <= s4_mag_r;
      s5_neg_r  <= s4_neg_r;
    end
  end

  // ---- force lanes, one per axis ----
  pipe_ctl_t                    ln_ctl;
  logic [NUM_LANES-1:0]         ln_v, ln_ovf, ln_neg;
  logic [NUM_LANES-1:0][CW-1:0] ln_quo;
  logic [1:0]                   ln_tag [NUM_LANES];

  assign ln_ctl = '{en: en, vld: s5_v_r};

  for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
    pfr_lane #(.MW(MW), .FW(FW), .DVW(DVW), .QB(CW)) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ln_ctl),
      .mag     (s5_mag_r[k]),
      .neg     (s5_neg_r[k]),
      .tag     (s5_zone_r),
      .factor  (s5_factor_r),
      .divisor (s5_div_r),
      .vld_o   (ln_v[k]),
      .quo_o   (ln_quo[k]),
      .ovf_o   (ln_ovf[k]),
      .neg_o   (ln_neg[k]),
      .tag_o   (ln_tag[k])
    );
  end

  // ---- clip, sign, flag merge and output buffer ----
  logic [NUM_LANES*CW-1:0] forces;

  pfr_merge #(.CW(CW)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .vld_i     (ln_v[0]),
    .quo_i     (ln_quo),
    .ovf_i     (ln_ovf),
    .neg_i     (ln_neg),
    .zone_i    (ln_tag[0]),
    .en_o      (en),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .force_o   (forces),
    .user_o    (out_tuser)
  );

  assign out_tdata = OUT_TW'(forces);

  // ---- checks ----
  // all lanes carry the same request in lockstep
  a_lane_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ln_v[0] |-> ln_v[1] && ln_v[2] && ln_tag[1] == ln_tag[0] && ln_tag[2] == ln_tag[0])
    else $error("force lanes out of step");

  // an apart pair carries no force and no clip flag
  a_apart_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] == ZONE_APART |-> forces == '0 && !out_tuser[2])
    else $error("nonzero force outside the safety zone");

  // the input side only holds off when results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output buffer");

  // the zone code never takes the unused value
  a_zone_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser[1:0] != 2'd3)
    else $error("undefined zone code at output");

endmodule
